### src/dqd_pkg.sv
// Package for the dual quadrature decoder: counter width, operation codes,
// transfer payload types and the x4 transition table. No dependencies.
`timescale 1ns / 1ps

package dqd_pkg;

	// Width of the position and error counters inside the block.
	localparam int COUNT_WIDTH = 32;
	// Width of the reported position and error count fields.
	localparam int OUT_WIDTH = 32;

	// Operation codes of an input item.
	typedef enum logic [2:0] {
		OP_SAMPLE = 3'd0,
		OP_READ   = 3'd1,
		OP_ZERO   = 3'd2,
		OP_LOAD   = 3'd3,
		OP_SEED   = 3'd4
	} op_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_INVERT_LEFT  = 1'b0,
		REG_INVERT_RIGHT = 1'b1
	} reg_index_t;

	// Effect of one pin transition.
	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_FWD  = 2'd1,
		STEP_BWD  = 2'd2,
		STEP_ERR  = 2'd3
	} step_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Input item payload.
	typedef struct packed {
		logic [2:0] opcode;
		logic       channel;
		logic       pin_a;
		logic       pin_b;
	} item_t;

	// Result item payload.
	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] position;
		logic [OUT_WIDTH-1:0]        error_count;
	} result_t;

	// Classify the code {a, b, prev_a, prev_b} of one x4 transition.
	function automatic step_t decode_step(input logic [3:0] code);
		step_t s;
		case (code)
			4'h1, 4'h8, 4'hE, 4'h7: s = STEP_FWD;
			4'h2, 4'hB, 4'hD, 4'h4: s = STEP_BWD;
			4'h3, 4'h6, 4'hC, 4'h9: s = STEP_ERR;
			default:                s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

### src/dual_quadrature_decoder_core.sv
// Top level of the dual quadrature decoder: input register, per-channel
// counters and result register. Depends on dqd_pkg.
`timescale 1ns / 1ps

// Two-channel x4 quadrature decoder.
// Input channel: item_valid / item_stall / item. An item transfers at a rising
// edge with item_valid high and item_stall low. Each item is a pin sample,
// a read, a position clear, a position load from the error count or a pin
// seed for the addressed channel.
// Result channel: result_valid / result_stall / result. Every item gives
// exactly one result: the addressed channel's position and error count after
// the item.
// Configuration channel: cfg_valid / cfg_ready / cfg_index / cfg_data sets the
// per-channel direction inversion; cfg_ready is always high.
// The result is registered: an item passes through the input register, then the
// result register. Throughput is one item per cycle while the receiver does not
// stall: the input register feeds a single pass of lookup and increment logic
// that updates the counters and loads the result register.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, then item_stall rises until the result moves.
// Reset clears all counters and previous pins, sets invert_left to 0 and
// invert_right to 1, and empties both registers.
module dual_quadrature_decoder_core
	import dqd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_index,
	input  logic    cfg_data
);

	logic   valid_s1;
	item_t  item_s1;
	logic   advance;
	logic   invert_left_q;
	logic   invert_right_q;
	logic [1:0] prev_pins_q [2];
	count_t pos_q [2];
	count_t err_q [2];
	logic   res_valid_q;
	result_t res_q;

	logic       ch;
	logic [1:0] cur_pins;
	step_t      step;
	logic       inv;
	count_t     pos_next;
	count_t     err_next;
	logic [1:0] pins_next;

	// The stage moves on when the result register is empty or being taken.
	assign advance    = !res_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Next state of the addressed channel.
	always_comb begin
		ch        = item_s1.channel;
		cur_pins  = {item_s1.pin_a, item_s1.pin_b};
		step      = decode_step({cur_pins, prev_pins_q[ch]});
		inv       = ch ? invert_right_q : invert_left_q;
		pos_next  = pos_q[ch];
		err_next  = err_q[ch];
		pins_next = prev_pins_q[ch];
		case (item_s1.opcode)
			OP_SAMPLE: begin
				pins_next = cur_pins;
				case (step)
					STEP_FWD: pos_next = inv ? pos_q[ch] - 1'b1 : pos_q[ch] + 1'b1;
					STEP_BWD: pos_next = inv ? pos_q[ch] + 1'b1 : pos_q[ch] - 1'b1;
					STEP_ERR: err_next = err_q[ch] + 1'b1;
					default:  ;
				endcase
			end
			OP_ZERO: pos_next = '0;
			OP_LOAD: pos_next = err_q[ch];
			OP_SEED: pins_next = cur_pins;
			default: ;
		endcase
	end

	// Channel state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_left_q  <= 1'b0;
			invert_right_q <= 1'b1;
			for (int i = 0; i < 2; i++) begin
				prev_pins_q[i] <= '0;
				pos_q[i]       <= '0;
				err_q[i]       <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INVERT_LEFT:  invert_left_q  <= cfg_data;
					REG_INVERT_RIGHT: invert_right_q <= cfg_data;
					default: ;
				endcase
			end
			if (valid_s1 && advance) begin
				prev_pins_q[ch] <= pins_next;
				pos_q[ch]       <= pos_next;
				err_q[ch]       <= err_next;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q.position    <= OUT_WIDTH'(signed'(pos_next));
			res_q.error_count <= OUT_WIDTH'(err_next);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	// The input side only stalls while an item waits in the input register.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item_stall high with empty input register");

	// A new result appears only after an item sat in the input register.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1))
		else $error("result appeared without an item");

	// A position clear reports zero.
	a_zero_reports_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && item_s1.opcode == OP_ZERO) |=> (result.position == '0))
		else $error("position clear did not report zero");

	// A read leaves both channels' counters untouched.
	a_read_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && item_s1.opcode == OP_READ)
		|=> ($stable(pos_q[0]) && $stable(pos_q[1]) && $stable(err_q[0]) && $stable(err_q[1])))
		else $error("read changed a counter");
`endif

endmodule

### bench/tb.sv
// Self-checking testbench for dual_quadrature_decoder_core: directed walks, inversion settings,
// back-pressure and random encoder traffic, each result checked against a local decoder mirror.
// Depends on dqd_pkg and the dual_quadrature_decoder_core RTL.
`timescale 1ns / 1ps

module tb;
	import dqd_pkg::*;

	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 40;
	localparam int IDLE_LIMIT    = 2000;
	localparam int OPCODE_LAST   = (1 << $bits(op_t)) - 1;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	item_t   item         = '0;
	logic    result_stall = 1'b0;
	logic    cfg_valid    = 1'b0;
	logic    cfg_index    = 1'b0;
	logic    cfg_data     = 1'b0;
	logic    item_stall;
	logic    result_valid;
	result_t result;
	logic    cfg_ready;

	dual_quadrature_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Mirror of the decoder state, updated when an item transfer happens.
	logic [1:0] pins_seen [2];
	count_t     position_now [2];
	count_t     errors_now [2];
	logic       invert_dir [2];
	result_t    pending_results [$];

	int mismatches  = 0;
	int idle_cycles = 0;
	bit tx_calm     = 1'b0;
	bit rx_calm     = 1'b0;
	bit hold_req    = 1'b0;
	bit offering    = 1'b0;

	always #1 clk = ~clk;

	// Position of a pin pair along the x4 cycle 00, 10, 11, 01.
	function automatic logic [1:0] pins_phase(logic [1:0] pins);
		return {pins[0], pins[1] ^ pins[0]};
	endfunction

	function automatic logic [1:0] phase_pins(logic [1:0] phase);
		return {phase[1] ^ phase[0], phase[1]};
	endfunction

	// A step of one phase forward or back is a count; two phases is a double transition.
	function automatic step_t classify_step(logic [1:0] prev, logic [1:0] now);
		logic [1:0] delta;
		delta = pins_phase(now) - pins_phase(prev);
		case (delta)
			2'd0: return STEP_NONE;
			2'd1: return STEP_FWD;
			2'd2: return STEP_ERR;
			default: return STEP_BWD;
		endcase
	endfunction

	// Apply one item to the mirror and return the result the block should give.
	function automatic result_t decode_item(item_t it);
		logic       ch;
		logic [1:0] now;
		step_t      step;
		result_t    r;
		ch = it.channel;
		now = {it.pin_a, it.pin_b};
		case (it.opcode)
			OP_SAMPLE: begin
				step = classify_step(pins_seen[ch], now);
				if (step == STEP_ERR)
					errors_now[ch] = errors_now[ch] + 1'b1;
				else if (step != STEP_NONE) begin
					if ((step == STEP_FWD) ^ invert_dir[ch])
						position_now[ch] = position_now[ch] + 1'b1;
					else
						position_now[ch] = position_now[ch] - 1'b1;
				end
				pins_seen[ch] = now;
			end
			OP_ZERO: position_now[ch] = '0;
			OP_LOAD: position_now[ch] = errors_now[ch];
			OP_SEED: pins_seen[ch] = now;
			default: ;
		endcase
		r.position = $signed(position_now[ch]);
		r.error_count = errors_now[ch];
		return r;
	endfunction

	// Mostly short idle stretches, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic item_t make_item(logic [2:0] op, logic ch, logic a, logic b);
		item_t it;
		it.opcode = op;
		it.channel = ch;
		it.pin_a = a;
		it.pin_b = b;
		return it;
	endfunction

	// Mostly legal encoder movement on a random channel, with other operations and noise.
	function automatic item_t random_item();
		item_t      it;
		int         pick;
		int         roll;
		logic [1:0] phase;
		it = item_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			phase = pins_phase(pins_seen[it.channel]);
			roll = $urandom_range(0, 9);
			if (roll == 0)
				phase = phase + 2'd2;
			else if (roll >= 3 && roll <= 6)
				phase = phase + 2'd1;
			else if (roll > 6)
				phase = phase - 2'd1;
			{it.pin_a, it.pin_b} = phase_pins(phase);
			it.opcode = OP_SAMPLE;
		end else if (pick < 77)
			it.opcode = OP_SEED;
		else if (pick < 84)
			it.opcode = OP_READ;
		else if (pick < 89)
			it.opcode = OP_ZERO;
		else if (pick < 94)
			it.opcode = OP_LOAD;
		return it;
	endfunction

	// Offer one item, record its expected result on transfer, then maybe go idle.
	task automatic send_item(item_t it);
		int gap;
		item <= it;
		item_valid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(decode_item(it));
		gap = (!tx_calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			item <= item_t'($urandom);
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (offering) begin
			item_valid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write both direction registers back to back; the block must be idle.
	task automatic set_inversion(logic left, logic right);
		cfg_valid <= 1'b1;
		cfg_index <= REG_INVERT_LEFT;
		cfg_data <= left;
		do @(posedge clk); while (!cfg_ready);
		invert_dir[REG_INVERT_LEFT] = left;
		cfg_index <= REG_INVERT_RIGHT;
		cfg_data <= right;
		do @(posedge clk); while (!cfg_ready);
		invert_dir[REG_INVERT_RIGHT] = right;
		cfg_valid <= 1'b0;
	endtask

	// A full forward cycle, a backward step, double transitions, no-change samples, clear and load.
	task automatic test_directed_walk();
		for (int ch = 0; ch < 2; ch++) begin
			send_item(make_item(OP_READ, 1'(ch), 1'b1, 1'b1));
			send_item(make_item(OP_SEED, 1'(ch), 1'b0, 1'b0));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b1, 1'b0));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b1, 1'b1));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b0, 1'b1));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b0, 1'b0));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b0, 1'b1));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b1, 1'b0));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b0, 1'b1));
			send_item(make_item(OP_SAMPLE, 1'(ch), 1'b0, 1'b1));
			send_item(make_item(OP_ZERO, 1'(ch), 1'b1, 1'b1));
			send_item(make_item(OP_LOAD, 1'(ch), 1'b1, 1'b0));
		end
		wait_drained();
	endtask

	// Opcodes beyond the defined set behave as a read and leave the pins alone.
	task automatic test_unused_opcodes();
		for (int op = OP_SEED + 1; op <= OPCODE_LAST; op++)
			send_item(make_item(3'(op), 1'b1, 1'b1, 1'b1));
		send_item(make_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1));
		wait_drained();
	endtask

	task automatic test_inversion_settings();
		for (int s = 0; s < 4; s++) begin
			set_inversion(s[0], s[1]);
			repeat (30) send_item(random_item());
			wait_drained();
		end
		set_inversion(1'b0, 1'b1);
	endtask

	// The receiver holds off while items keep coming, so the input side must stall.
	task automatic test_back_pressure();
		tx_calm = 1'b1;
		hold_req = 1'b1;
		repeat (30) send_item(random_item());
		wait_drained();
		tx_calm = 1'b0;
	endtask

	// Bursts separated by full drains of the pipeline.
	task automatic test_sender_pause();
		repeat (3) begin
			repeat (15) send_item(random_item());
			wait_drained();
		end
	endtask

	task automatic test_random_traffic();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		repeat (50) send_item(random_item());
		wait_drained();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (280) send_item(random_item());
		wait_drained();
	endtask

	// Receiver side: random stalls, or one long hold when a test asks for it.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat (gap_len()) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: position %0d error_count %0d",
					result.position, result.error_count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, result.position);
					mismatches++;
				end
				if (result.error_count !== want.error_count) begin
					$error("error_count: expected %0d, got %0d",
						want.error_count, result.error_count);
					mismatches++;
				end
			end
		end
	end

	// End the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		for (int ch = 0; ch < 2; ch++) begin
			pins_seen[ch] = '0;
			position_now[ch] = '0;
			errors_now[ch] = '0;
		end
		invert_dir[REG_INVERT_LEFT] = 1'b0;
		invert_dir[REG_INVERT_RIGHT] = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_walk();
		test_unused_opcodes();
		test_inversion_settings();
		test_back_pressure();
		test_sender_pause();
		test_random_traffic();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
